// ===== rtl/disjoint_interval_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// Disjoint interval tracker assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DISJOINT_INTERVAL_TRACKER_ASSERT_SVH
`define DISJOINT_INTERVAL_TRACKER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define DIT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("disjoint_interval_tracker: assertion failed");
// Next-cycle implication.
`define DIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("disjoint_interval_tracker: assertion failed");
`else
`define DIT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DIT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/dit_pkg.sv =====
// ----------------------------------------------------------------------------
// Disjoint interval tracker package
// Field widths, word types, status codes and sequencer states.
// ----------------------------------------------------------------------------
package dit_pkg;

   localparam int ValueW  = 16;
   localparam int StatusW = 3;
   localparam int CountW  = 6;

   typedef logic [ValueW-1:0] value_type;
   typedef logic [CountW-1:0] count_type;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_DUMP = 1'b1
   } op_type;

   typedef enum logic [StatusW-1:0] {
      ST_NEW      = 3'd0,
      ST_EXTEND   = 3'd1,
      ST_BRIDGE   = 3'd2,
      ST_COVERED  = 3'd3,
      ST_FULL     = 3'd4,
      ST_INTERVAL = 3'd5,
      ST_EMPTY    = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT_UP,
      S_INSERT,
      S_SHIFT_DN,
      S_EMIT,
      S_DUMP
   } state_type;

endpackage

// ===== rtl/dit_if.sv =====
// ----------------------------------------------------------------------------
// Disjoint interval tracker channels
// Valid/ready interfaces for the request and response words.
// ----------------------------------------------------------------------------
interface dit_req_if;
   import dit_pkg::*;

   logic      valid;
   logic      ready;
   op_type    operation;
   value_type value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface dit_rsp_if;
   import dit_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   value_type  interval_start;
   value_type  interval_end;
   count_type  interval_count;
   logic       last;

   modport source (output valid, output status, output interval_start,
                   output interval_end, output interval_count, output last,
                   input ready);
   modport sink   (input valid, input status, input interval_start,
                   input interval_end, input interval_count, input last,
                   output ready);
endinterface

// ===== rtl/dit_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module dit_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds while the enable is low.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/disjoint_interval_tracker.sv =====
// ----------------------------------------------------------------------------
// Disjoint interval tracker
// Sorted table of disjoint closed intervals with add-and-merge and dump.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Words per item         | Payload
//  req_ch   | in        | 1                      | operation, value
//  rsp_ch   | out       | 1 per add, N per dump  | status, interval_start/end,
//           |           | (1 when table empty)   | interval_count, last
//
// An add with N stored intervals scans until it meets a larger start or runs
// past the end. It then takes a decide step, a shift step for each entry
// moved by an insert or merge, an insert write after an upward move, and a
// response step. This pace is set by the table RAM, which gives one read and
// one write a cycle, and by the single comparator that walks the table.
// A dump gives one word a cycle while the output is taken.
// Reset is synchronous; it clears the interval count, the sequencer and the
// response valid only.
// A stalled response holds the sequencer in its emit or dump state and holds
// the output register; a new request is taken as soon as the sequencer is idle again.
// ----------------------------------------------------------------------------
`include "disjoint_interval_tracker_assert.svh"

module disjoint_interval_tracker #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   dit_req_if.sink     req_ch,
   dit_rsp_if.source   rsp_ch
);
   import dit_pkg::*;

   localparam int AddrBits  = $clog2(CAPACITY);
   localparam int CntBits   = $clog2(CAPACITY + 1);
   localparam int EntryBits = 2 * ValueW;
   localparam logic [CntBits-1:0] CntOne  = CntBits'(1);
   localparam logic [CntBits-1:0] CntCap  = CntBits'(CAPACITY);
   localparam logic [ValueW:0]    WideOne = (ValueW + 1)'(1);
   localparam logic [ValueW-1:0]  ValZero = '0;

   // Sequencer and table bookkeeping.
   state_type             state_ff, state_in;
   logic [CntBits-1:0]    count_ff, count_in;
   logic [CntBits-1:0]    idx_ff, idx_in;
   logic [CntBits-1:0]    pos_ff, pos_in;
   logic [ValueW-1:0]     v_ff, v_in;
   logic [ValueW-1:0]     prev_start_ff, prev_start_in;
   logic [ValueW-1:0]     prev_end_ff, prev_end_in;
   logic [ValueW-1:0]     cur_start_ff, cur_start_in;
   logic [ValueW-1:0]     cur_end_ff, cur_end_in;

   // Pending add result.
   status_type            res_status_ff, res_status_in;
   logic [ValueW-1:0]     res_start_ff, res_start_in;
   logic [ValueW-1:0]     res_end_ff, res_end_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   value_type             rsp_start_ff, rsp_start_in;
   value_type             rsp_end_ff, rsp_end_in;
   count_type             rsp_count_ff, rsp_count_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Table RAM port signals.
   logic                  ram_wr_en, ram_rd_en;
   logic [AddrBits-1:0]   ram_wr_addr, ram_rd_addr;
   logic [EntryBits-1:0]  ram_wr_data, ram_rd_data;
   logic [ValueW-1:0]     q_start, q_end;

   // Emit path.
   logic                  emit;
   status_type            emit_status;
   logic [ValueW-1:0]     emit_start, emit_end;
   logic                  emit_last;
   logic                  out_free;

   // Decision terms.
   logic                  req_fire;
   logic [ValueW-1:0]     req_v;
   logic [CntBits-1:0]    idx_inc, idx_dec, pos_inc, pos_dec, count_inc, count_dec;
   logic                  scan_above, scan_at_end, dump_last;
   logic                  has_prev, has_cur, covered, touch_left, touch_right, is_full;
   logic [ValueW:0]       prev_end_wide_inc, v_wide_inc;

   // Assertion terms.
   logic                  rsp_is_empty, rsp_empty_ok, drop_now;

   dit_ram #(
      .WIDTH (EntryBits),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign q_start = ram_rd_data[EntryBits-1:ValueW];
   assign q_end   = ram_rd_data[ValueW-1:0];

   // Handshake terms.
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_v        = req_ch.value;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // Index arithmetic.
   assign idx_inc   = idx_ff + CntOne;
   assign idx_dec   = idx_ff - CntOne;
   assign pos_inc   = pos_ff + CntOne;
   assign pos_dec   = pos_ff - CntOne;
   assign count_inc = count_ff + CntOne;
   assign count_dec = count_ff - CntOne;

   // The scan comparator: walks the table one entry a cycle.
   assign scan_above  = (q_start > v_ff);
   assign scan_at_end = (idx_inc == count_ff);
   assign dump_last   = (idx_inc == count_ff);

   // Neighbor tests, compared one bit wider so the top value never wraps.
   assign has_prev          = (pos_ff != '0);
   assign has_cur           = (pos_ff != count_ff);
   assign prev_end_wide_inc = {1'b0, prev_end_ff} + WideOne;
   assign v_wide_inc        = {1'b0, v_ff} + WideOne;
   assign covered           = has_prev && (prev_end_ff >= v_ff);
   assign touch_left        = has_prev && (prev_end_wide_inc == {1'b0, v_ff});
   assign touch_right       = has_cur && ({1'b0, cur_start_ff} == v_wide_inc);
   assign is_full           = (count_ff == CntCap);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_ch.operation == OP_DUMP) begin
                  state_in = (count_ff == '0) ? S_EMIT : S_DUMP;
               end else begin
                  state_in = (count_ff == '0) ? S_DECIDE : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_above || scan_at_end) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (covered) begin
               state_in = S_EMIT;
            end else if (touch_left && touch_right) begin
               state_in = (pos_inc < count_ff) ? S_SHIFT_DN : S_EMIT;
            end else if (touch_left || touch_right || is_full) begin
               state_in = S_EMIT;
            end else begin
               state_in = (pos_ff == count_ff) ? S_EMIT : S_SHIFT_UP;
            end
         end
         S_SHIFT_UP: begin
            if (idx_ff == pos_ff) begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            state_in = S_EMIT;
         end
         S_SHIFT_DN: begin
            if (idx_ff == count_ff) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_DUMP: begin
            if (out_free && dump_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs: table accesses, bookkeeping and the emitted word.
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      v_in          = v_ff;
      prev_start_in = prev_start_ff;
      prev_end_in   = prev_end_ff;
      cur_start_in  = cur_start_ff;
      cur_end_in    = cur_end_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_end_in    = res_end_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;
      emit          = 1'b0;
      emit_status   = res_status_ff;
      emit_start    = res_start_ff;
      emit_end      = res_end_ff;
      emit_last     = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               v_in   = req_v;
               idx_in = '0;
               pos_in = '0;
               if (req_ch.operation == OP_DUMP && count_ff == '0) begin
                  res_status_in = ST_EMPTY;
                  res_start_in  = ValZero;
                  res_end_in    = ValZero;
               end else if (count_ff != '0) begin
                  ram_rd_en = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (scan_above) begin
               pos_in       = idx_ff;
               cur_start_in = q_start;
               cur_end_in   = q_end;
            end else begin
               prev_start_in = q_start;
               prev_end_in   = q_end;
               if (scan_at_end) begin
                  pos_in = idx_inc;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_inc[AddrBits-1:0];
                  idx_in      = idx_inc;
               end
            end
         end
         S_DECIDE: begin
            if (covered) begin
               res_status_in = ST_COVERED;
               res_start_in  = prev_start_ff;
               res_end_in    = prev_end_ff;
            end else if (touch_left && touch_right) begin
               // Bridge: the left neighbor absorbs the right one.
               ram_wr_en     = 1'b1;
               ram_wr_addr   = pos_dec[AddrBits-1:0];
               ram_wr_data   = {prev_start_ff, cur_end_ff};
               count_in      = count_dec;
               res_status_in = ST_BRIDGE;
               res_start_in  = prev_start_ff;
               res_end_in    = cur_end_ff;
               if (pos_inc < count_ff) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = pos_inc[AddrBits-1:0];
                  idx_in      = pos_inc;
               end
            end else if (touch_left) begin
               ram_wr_en     = 1'b1;
               ram_wr_addr   = pos_dec[AddrBits-1:0];
               ram_wr_data   = {prev_start_ff, v_ff};
               res_status_in = ST_EXTEND;
               res_start_in  = prev_start_ff;
               res_end_in    = v_ff;
            end else if (touch_right) begin
               ram_wr_en     = 1'b1;
               ram_wr_addr   = pos_ff[AddrBits-1:0];
               ram_wr_data   = {v_ff, cur_end_ff};
               res_status_in = ST_EXTEND;
               res_start_in  = v_ff;
               res_end_in    = cur_end_ff;
            end else if (is_full) begin
               res_status_in = ST_FULL;
               res_start_in  = ValZero;
               res_end_in    = ValZero;
            end else begin
               // New single interval; open a slot unless it goes at the end.
               count_in      = count_inc;
               res_status_in = ST_NEW;
               res_start_in  = v_ff;
               res_end_in    = v_ff;
               if (pos_ff == count_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = pos_ff[AddrBits-1:0];
                  ram_wr_data = {v_ff, v_ff};
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = count_dec[AddrBits-1:0];
                  idx_in      = count_dec;
               end
            end
         end
         S_SHIFT_UP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_inc[AddrBits-1:0];
            ram_wr_data = ram_rd_data;
            if (idx_ff != pos_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_dec[AddrBits-1:0];
               idx_in      = idx_dec;
            end
         end
         S_INSERT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[AddrBits-1:0];
            ram_wr_data = {v_ff, v_ff};
         end
         S_SHIFT_DN: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_dec[AddrBits-1:0];
            ram_wr_data = ram_rd_data;
            if (idx_ff != count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_inc[AddrBits-1:0];
               idx_in      = idx_inc;
            end
         end
         S_EMIT: begin
            emit = 1'b1;
         end
         S_DUMP: begin
            emit        = 1'b1;
            emit_status = ST_INTERVAL;
            emit_start  = q_start;
            emit_end    = q_end;
            emit_last   = dump_last;
            if (out_free && !dump_last) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_inc[AddrBits-1:0];
               idx_in      = idx_inc;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Output register load.
   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
         rsp_start_in  = emit_start;
         rsp_end_in    = emit_end;
         rsp_count_in  = CountW'(count_ff);
         rsp_last_in   = emit_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      v_ff          <= v_in;
      prev_start_ff <= prev_start_in;
      prev_end_ff   <= prev_end_in;
      cur_start_ff  <= cur_start_in;
      cur_end_ff    <= cur_end_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_end_ff    <= res_end_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.interval_start = rsp_start_ff;
   assign rsp_ch.interval_end   = rsp_end_ff;
   assign rsp_ch.interval_count = rsp_count_ff;
   assign rsp_ch.last           = rsp_last_ff;

   // Terms that the checks below look at.
   assign rsp_is_empty = rsp_valid_ff && (rsp_status_ff == ST_EMPTY);
   assign rsp_empty_ok = (rsp_count_ff == '0) && rsp_last_ff;
   assign drop_now     = (state_ff == S_DECIDE) && (res_status_in == ST_FULL);

   // The table never holds more intervals than it has room for.
   `DIT_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CntCap)
   // The interval count only moves on a decision cycle.
   `DIT_ASSERT_IMPLY(a_count_on_decide, clock, reset, count_in != count_ff, state_ff == S_DECIDE)
   // An empty-table word reports no intervals and closes its dump.
   `DIT_ASSERT_IMPLY(a_empty_word, clock, reset, rsp_is_empty, rsp_empty_ok)
   // A dropped value only happens with the table full, and leaves it full.
   `DIT_ASSERT_NEXT(a_full_drop, clock, reset, drop_now, count_ff == CntCap)

endmodule

// ===== tb/sv/disjoint_interval_tracker_checker.sv =====
// ----------------------------------------------------------------------------
// Disjoint interval tracker checker
// Watches the request and response channels and keeps its own sorted table of
// intervals. Each accepted request is turned into the response words it must
// cause. Each accepted response word is compared field by field with the
// oldest of those words, and every difference is counted.
// ----------------------------------------------------------------------------
module disjoint_interval_tracker_checker #(
   parameter int TableDepth = 32
) (
   input  logic clock,
   input  logic reset,
   dit_req_if   req_mon,
   dit_rsp_if   rsp_mon,
   output int   mismatches,
   output int   words_owed,
   output int   adds_seen,
   output int   dumps_seen,
   output int   words_seen,
   output int   bridges_seen,
   output int   drops_seen,
   output int   peak_entries
);
   timeunit 1ns;
   timeprecision 1ps;
   import dit_pkg::*;

   typedef struct packed {
      status_type status;
      value_type  lo;
      value_type  hi;
      count_type  count;
      logic       fin;
   } interval_word_type;

   // Shadow copy of the interval table, kept sorted by start.
   value_type lo_tab [TableDepth];
   value_type hi_tab [TableDepth];
   int        n_stored;

   // Response words that the block still owes, oldest first.
   interval_word_type owed_words [$];

   // Queue one expected word; the count is the table size after this step.
   function automatic void owe(status_type s, value_type lo, value_type hi, logic fin);
      interval_word_type w;
      w.status = s;
      w.lo     = lo;
      w.hi     = hi;
      w.count  = count_type'(n_stored);
      w.fin    = fin;
      owed_words = {owed_words, w};
   endfunction

   // Add one value to the shadow table and work out its status word.
   function automatic void merge_value(value_type v);
      int pos;
      bit joins_left;
      bit joins_right;
      pos = 0;
      while (pos < n_stored && lo_tab[pos] <= v) pos++;

      // The interval just below already holds the value.
      if (pos > 0 && hi_tab[pos-1] >= v) begin
         owe(ST_COVERED, lo_tab[pos-1], hi_tab[pos-1], 1'b1);
         return;
      end

      // Adjacency is tested at 17 bits so the top value never wraps to zero.
      joins_left  = (pos > 0) && ({1'b0, hi_tab[pos-1]} + 17'd1 == {1'b0, v});
      joins_right = (pos < n_stored) && ({1'b0, lo_tab[pos]} == {1'b0, v} + 17'd1);

      if (joins_left && joins_right) begin
         hi_tab[pos-1] = hi_tab[pos];
         for (int i = pos; i + 1 < n_stored; i++) begin
            lo_tab[i] = lo_tab[i+1];
            hi_tab[i] = hi_tab[i+1];
         end
         n_stored--;
         bridges_seen++;
         owe(ST_BRIDGE, lo_tab[pos-1], hi_tab[pos-1], 1'b1);
      end else if (joins_left) begin
         hi_tab[pos-1] = v;
         owe(ST_EXTEND, lo_tab[pos-1], v, 1'b1);
      end else if (joins_right) begin
         lo_tab[pos] = v;
         owe(ST_EXTEND, v, hi_tab[pos], 1'b1);
      end else if (n_stored >= TableDepth) begin
         drops_seen++;
         owe(ST_FULL, '0, '0, 1'b1);
      end else begin
         for (int i = n_stored; i > pos; i--) begin
            lo_tab[i] = lo_tab[i-1];
            hi_tab[i] = hi_tab[i-1];
         end
         lo_tab[pos] = v;
         hi_tab[pos] = v;
         n_stored++;
         if (n_stored > peak_entries) peak_entries = n_stored;
         owe(ST_NEW, v, v, 1'b1);
      end
   endfunction

   // A dump lists every stored interval, or one empty marker.
   function automatic void list_intervals();
      if (n_stored == 0) begin
         owe(ST_EMPTY, '0, '0, 1'b1);
      end else begin
         for (int i = 0; i < n_stored; i++)
            owe(ST_INTERVAL, lo_tab[i], hi_tab[i], logic'(i + 1 == n_stored));
      end
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Responses are handled before requests, since a word accepted at this edge
   // can never belong to a request accepted at the same edge.
   always @(posedge clock) begin
      interval_word_type want;
      if (reset) begin
         n_stored = 0;
         owed_words.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            words_seen++;
            if (owed_words.size() == 0) begin
               $error("unexpected response word: status %0d start %0d end %0d",
                      rsp_mon.status, rsp_mon.interval_start, rsp_mon.interval_end);
               mismatches++;
            end else begin
               want = owed_words.pop_front();
               compare_field("status", want.status, rsp_mon.status);
               compare_field("interval_start", want.lo, rsp_mon.interval_start);
               compare_field("interval_end", want.hi, rsp_mon.interval_end);
               compare_field("interval_count", want.count, rsp_mon.interval_count);
               compare_field("last", want.fin, rsp_mon.last);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.operation == OP_DUMP) begin
               dumps_seen++;
               list_intervals();
            end else begin
               adds_seen++;
               merge_value(req_mon.value);
            end
         end
      end
      words_owed = owed_words.size();
   end

endmodule

// ===== tb/sv/disjoint_interval_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// Disjoint interval tracker testbench
// Drives a short directed sequence of adds and dumps, then random adds that
// mostly land in a moving narrow window so that extends, merges, covered
// values and a full table all occur. Both channels idle at random in phases,
// and the response side holds off once for a long stretch. Checking is done
// by the checker module; this top makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module disjoint_interval_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dit_pkg::*;

   localparam int TableDepth    = 32;
   localparam int RandomItems   = 282;
   localparam int WindowSpan    = 64;
   localparam int WindowItems   = 40;
   localparam int BacklogAt     = 230;
   localparam int BacklogCycles = 400;
   localparam int SettleCycles  = 100;
   localparam int StallLimit    = 3000;

   logic clock;
   logic reset;

   dit_req_if req_ch ();
   dit_rsp_if rsp_ch ();

   int mismatches;
   int words_owed;
   int adds_seen;
   int dumps_seen;
   int words_seen;
   int bridges_seen;
   int drops_seen;
   int peak_entries;

   int words_sent   = 0;
   int send_gap_pct = 0;
   int take_gap_pct = 0;
   int stall_cycles = 0;
   bit backlog_done = 1'b0;

   disjoint_interval_tracker #(
      .CAPACITY (TableDepth)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   disjoint_interval_tracker_checker #(
      .TableDepth (TableDepth)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .mismatches   (mismatches),
      .words_owed   (words_owed),
      .adds_seen    (adds_seen),
      .dumps_seen   (dumps_seen),
      .words_seen   (words_seen),
      .bridges_seen (bridges_seen),
      .drops_seen   (drops_seen),
      .peak_entries (peak_entries)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Idle rates follow the run: sender light and receiver heavy, then the
   // reverse, then no idling at all.
   function automatic void set_gap_rates();
      if (words_sent < 100) begin
         send_gap_pct = 18;
         take_gap_pct = 53;
      end else if (words_sent < 200) begin
         send_gap_pct = 53;
         take_gap_pct = 18;
      end else begin
         send_gap_pct = 0;
         take_gap_pct = 0;
      end
   endfunction

   // Offer one request word and return at the edge where it is taken.
   task automatic send_word(op_type op, value_type v);
      set_gap_rates();
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.value     <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic add_value(value_type v);
      send_word(OP_ADD, v);
   endtask

   // Request side: reset, directed words, random words, then the verdict.
   initial begin
      int unsigned window_base;
      int unsigned pick;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_ADD;
      req_ch.value     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty dump, both ends of the range, extends on either
      // side, a covered value, a bridging merge and dumps of the result.
      send_word(OP_DUMP, 16'h0000);
      add_value(16'h0000);
      add_value(16'hFFFF);
      add_value(16'hFFFE);
      add_value(16'h0001);
      add_value(16'h0001);
      add_value(16'h0003);
      add_value(16'h0002);
      send_word(OP_DUMP, 16'hFFFF);
      add_value(16'h8000);
      add_value(16'h7FFF);
      add_value(16'h8001);
      add_value(16'h8000);
      add_value(16'h5555);
      add_value(16'hAAAA);
      add_value(16'h5557);
      add_value(16'h5556);
      send_word(OP_DUMP, 16'h5A5A);

      // Random part: most values fall in a narrow window that moves now and
      // then, the rest are anywhere in the range or dumps.
      window_base = 0;
      for (int k = 0; k < RandomItems; k++) begin
         if (k % WindowItems == 0)
            window_base = $urandom_range(0, 16'hFFFF - (WindowSpan - 1));
         pick = $urandom_range(0, 99);
         if (pick < 10)
            send_word(OP_DUMP, value_type'($urandom));
         else if (pick < 25)
            add_value(value_type'($urandom));
         else
            add_value(value_type'(window_base + $urandom_range(0, WindowSpan - 1)));
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("Run covered %0d adds and %0d dumps giving %0d response words.",
               adds_seen, dumps_seen, words_seen);
      $display("Saw %0d bridging merges, %0d values dropped on a full table, peak %0d intervals.",
               bridges_seen, drops_seen, peak_entries);
      if (mismatches == 0) begin
         $display("** disjoint_interval_tracker: PASSED **");
      end else begin
         $display("** disjoint_interval_tracker: FAILED **");
      end
      $finish;
   end

   // Response side: random stalls, plus one long hold-off so the block
   // backs up and stops taking requests.
   initial begin
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!backlog_done && words_sent >= BacklogAt) begin
            backlog_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (BacklogCycles) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= take_gap_pct);
         end
      end
   end

   // Watchdog: ends the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("Watchdog expired with %0d response words still owed.", words_owed);
         $display("** disjoint_interval_tracker: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dit_pkg.sv
rtl/dit_if.sv
rtl/dit_ram.sv
rtl/disjoint_interval_tracker.sv
tb/sv/disjoint_interval_tracker_checker.sv
tb/sv/disjoint_interval_tracker_tb.sv
